// ===== src/pvsd_pkg.sv =====
// Shared types, codes and helpers for the prefix varint stream decoder.
`default_nettype none
package pvsd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CountW = 4;
  localparam int unsigned TypeShift = 56;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SECOND = 2'd1,
    ST_ZERO_DOCID = 2'd2
  } status_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } item_t;

  // Counts the leading one bits of a header byte.
  function automatic logic [CountW-1:0] lead_ones(input logic [ByteW-1:0] h);
    logic [CountW-1:0] n;
    logic              run;
    n   = '0;
    run = 1'b1;
    for (int i = ByteW - 1; i >= 0; i--) begin
      if (run && h[i]) begin
        n = n + 1'b1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== src/prefix_varint_stream_decoder.sv =====
// Top level of the prefix varint stream decoder with its mode register.
// A completing byte passes the input register, then the core, which sets out_valid.
// Throughput: one byte per cycle while the result side keeps taking requests.
// The input register and the result register each hold one request, so one more
// byte is taken while a finished result waits.
// Synchronous reset clears the decode state, the mode register and both valid flags.
`default_nettype none
module prefix_varint_stream_decoder
  import pvsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [ByteW-1:0]  in_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ValueW-1:0]      value,
  output logic [1:0]             status
);

  logic  docid_mode;
  item_t item;
  logic  take;

  always_ff @(posedge clk) begin
    if (rst) begin
      docid_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      docid_mode <= cfg_wr_data;
    end
  end

  pvsd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .item     (item),
    .take     (take)
  );

  pvsd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .docid_mode (docid_mode),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .status     (status)
  );

  // Results that report an error carry a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> value == '0)
    else $error("error result with nonzero value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_BAD_SECOND || status == ST_ZERO_DOCID))
    else $error("undefined status code");

  // Input stalls only when a held byte is blocked by an untaken result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> item.valid && out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  // A byte that is taken leaves the input register unless a new one arrives.
  a_take_drains: assert property (@(posedge clk) disable iff (rst)
    take && !in_valid |=> !item.valid)
    else $error("input register did not drain");

endmodule
`default_nettype wire

// ===== src/pvsd_in_stage.sv =====
// Input register stage that holds one accepted byte until the core takes it.
`default_nettype none
module pvsd_in_stage
  import pvsd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [ByteW-1:0] in_byte,
  output item_t                 item,
  input  wire logic             take
);

  logic             q_valid;
  logic [ByteW-1:0] q_byte;

  assign in_ready = !q_valid || take;
  assign item     = '{valid: q_valid, data: q_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      q_valid <= 1'b1;
    end else if (take) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_byte <= in_byte;
    end
  end

endmodule
`default_nettype wire

// ===== src/pvsd_core.sv =====
// Decode state machine and result register of the prefix varint decoder.
`default_nettype none
module pvsd_core
  import pvsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              docid_mode,
  input  wire item_t             item,
  output logic                   take,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ValueW-1:0]      value,
  output logic [1:0]             status
);

  typedef enum logic [1:0] {
    PH_START   = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_SECOND  = 2'd3
  } phase_t;

  phase_t              phase, phase_next;
  logic [CountW-1:0]   bytes_left, bytes_left_next, bl_dec, ones;
  logic [ValueW-1:0]   accumulator, accumulator_next, fin_v, res_value;
  logic [ByteW-1:0]    type_byte, type_byte_next, b;
  logic                fin, res_valid;
  status_t             res_status;

  assign b    = item.data;
  assign take = item.valid && (!out_valid || out_ready);

  always_comb begin
    phase_next       = phase;
    bytes_left_next  = bytes_left;
    accumulator_next = accumulator;
    type_byte_next   = type_byte;
    fin              = 1'b0;
    fin_v            = '0;
    res_valid        = 1'b0;
    res_value        = '0;
    res_status       = ST_OK;
    ones             = lead_ones(b);
    bl_dec           = (bytes_left != '0) ? bytes_left - 1'b1 : '0;
    unique case (phase)
      PH_START, PH_HEADER: begin
        if (phase == PH_START && docid_mode) begin
          type_byte_next = b;
          phase_next     = PH_HEADER;
        end else if (!b[ByteW-1]) begin
          fin   = 1'b1;
          fin_v = ValueW'(b);
        end else if (b == 8'hFF) begin
          phase_next = PH_SECOND;
        end else begin
          accumulator_next = ValueW'(b & (8'hFF >> (ones + 1'b1)));
          bytes_left_next  = ones;
          phase_next       = PH_PAYLOAD;
        end
      end
      PH_SECOND: begin
        if (!b[7]) begin
          accumulator_next = ValueW'(b & 8'h7F);
          bytes_left_next  = CountW'(7);
          phase_next       = PH_PAYLOAD;
        end else if ((b & 8'hC0) == 8'h80) begin
          accumulator_next = '0;
          bytes_left_next  = CountW'(8);
          phase_next       = PH_PAYLOAD;
        end else begin
          phase_next       = PH_START;
          bytes_left_next  = '0;
          accumulator_next = '0;
          res_valid        = 1'b1;
          res_status       = ST_BAD_SECOND;
        end
      end
      PH_PAYLOAD: begin
        accumulator_next = {accumulator[ValueW-ByteW-1:0], b};
        bytes_left_next  = bl_dec;
        if (bl_dec == '0) begin
          fin   = 1'b1;
          fin_v = accumulator_next;
        end
      end
      default: begin
        phase_next = PH_START;
      end
    endcase

    if (fin) begin
      phase_next       = PH_START;
      bytes_left_next  = '0;
      accumulator_next = '0;
      res_valid        = 1'b1;
      if (docid_mode && fin_v == '0) begin
        res_status = ST_ZERO_DOCID;
      end else if (docid_mode) begin
        res_value = fin_v + {type_byte, {TypeShift{1'b0}}};
      end else begin
        res_value = fin_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      bytes_left  <= '0;
      accumulator <= '0;
      type_byte   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        phase       <= phase_next;
        bytes_left  <= bytes_left_next;
        accumulator <= accumulator_next;
        type_byte   <= type_byte_next;
      end
      if (take && res_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      value  <= res_value;
      status <= res_status;
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb_prefix_varint_stream_decoder.sv =====
// Self-checking testbench for the prefix varint stream decoder.
`timescale 1ns / 1ps
module tb_prefix_varint_stream_decoder
  import pvsd_pkg::*;
();

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned PhaseBytes    = 375;
  localparam int unsigned RandomPhases  = 4;

  typedef enum logic [1:0] {
    WAIT_LEAD,
    WAIT_HEADER,
    IN_PAYLOAD,
    WAIT_SECOND
  } dec_phase_t;

  class decode_tracker;
    bit                 docid;
    dec_phase_t         ph;
    int unsigned        left;
    logic [ValueW-1:0]  acc;
    logic [ByteW-1:0]   kind;
    logic [ValueW-1:0]  want_value[$];
    status_t            want_status[$];
    int unsigned        errors;

    function new();
      docid  = 1'b0;
      ph     = WAIT_LEAD;
      left   = 0;
      acc    = '0;
      kind   = '0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return want_value.size();
    endfunction

    function void complete(logic [ValueW-1:0] v);
      ph   = WAIT_LEAD;
      left = 0;
      acc  = '0;
      if (docid && v == '0) begin
        want_value.push_back('0);
        want_status.push_back(ST_ZERO_DOCID);
      end else begin
        if (docid) begin
          v = v + {kind, 56'd0};
        end
        want_value.push_back(v);
        want_status.push_back(ST_OK);
      end
    endfunction

    function void take_header(logic [ByteW-1:0] h);
      int unsigned ones;
      ones = 0;
      if (!h[7]) begin
        complete({56'd0, h});
      end else if (h == 8'hFF) begin
        ph = WAIT_SECOND;
      end else begin
        while (ones < 8 && h[7 - ones]) ones++;
        acc  = {56'd0, h & (8'hFF >> (ones + 1))};
        left = ones;
        ph   = IN_PAYLOAD;
      end
    endfunction

    // Advances the decode state by one accepted request byte.
    function void take_byte(logic [ByteW-1:0] b);
      case (ph)
        WAIT_LEAD: begin
          if (docid) begin
            kind = b;
            ph   = WAIT_HEADER;
          end else begin
            take_header(b);
          end
        end
        WAIT_HEADER: begin
          take_header(b);
        end
        WAIT_SECOND: begin
          if (!b[7]) begin
            acc  = {57'd0, b[6:0]};
            left = 7;
            ph   = IN_PAYLOAD;
          end else if (b[7:6] == 2'b10) begin
            acc  = '0;
            left = 8;
            ph   = IN_PAYLOAD;
          end else begin
            ph   = WAIT_LEAD;
            left = 0;
            acc  = '0;
            want_value.push_back('0);
            want_status.push_back(ST_BAD_SECOND);
          end
        end
        default: begin
          acc = {acc[ValueW-9:0], b};
          if (left > 0) left--;
          if (left == 0) complete(acc);
        end
      endcase
    endfunction

    function void check_result(logic [ValueW-1:0] v, logic [1:0] s);
      logic [ValueW-1:0] ev;
      status_t           es;
      if (want_value.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %h status %0d",
                 $time, v, s);
        errors++;
      end else begin
        ev = want_value.pop_front();
        es = want_status.pop_front();
        if (v !== ev) begin
          $display("%0t: value mismatch, expected %h, got %h", $time, ev, v);
          errors++;
        end
        if (s !== es) begin
          $display("%0t: status mismatch, expected %0d, got %0d", $time, es, s);
          errors++;
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic              cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  logic [ByteW-1:0]  in_byte;
  logic              out_valid;
  logic              out_ready;
  logic [ValueW-1:0] value;
  logic [1:0]        status;

  decode_tracker     tracker;
  logic [ByteW-1:0]  tx_bytes[$];
  bit                send_calm;

  prefix_varint_stream_decoder DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .status     (status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Appends the encoding of v in len bytes, 1 to 10; v is cut to what fits.
  task automatic add_value(input int unsigned len, input logic [ValueW-1:0] v);
    logic [ValueW-1:0] w;
    logic [ByteW-1:0]  hdr;
    int unsigned       i;
    if (len <= 8) begin
      w   = v & ((64'd1 << (7 * len)) - 64'd1);
      hdr = ~(8'hFF >> (len - 1));
      hdr = hdr | 8'(w >> (8 * (len - 1)));
      tx_bytes.push_back(hdr);
      for (i = len - 1; i >= 1; i--) tx_bytes.push_back(8'(w >> (8 * (i - 1))));
    end else if (len == 9) begin
      tx_bytes.push_back(8'hFF);
      tx_bytes.push_back({1'b0, v[62:56]});
      for (i = 7; i >= 1; i--) tx_bytes.push_back(8'(v >> (8 * (i - 1))));
    end else begin
      tx_bytes.push_back(8'hFF);
      tx_bytes.push_back({2'b10, 6'($urandom)});
      for (i = 8; i >= 1; i--) tx_bytes.push_back(8'(v >> (8 * (i - 1))));
    end
  endtask

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 64'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic build_random(input bit docid);
    int unsigned r;
    while (tx_bytes.size() < PhaseBytes) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        if (docid) tx_bytes.push_back(8'($urandom));
        add_value($urandom_range(1, 10), pick_value());
      end else if (r < 93) begin
        if (docid) tx_bytes.push_back(8'($urandom));
        tx_bytes.push_back(8'hFF);
        tx_bytes.push_back({2'b11, 6'($urandom)});
      end else begin
        tx_bytes.push_back(8'($urandom));
      end
    end
  endtask

  task automatic send_stream();
    int unsigned      gap;
    logic [ByteW-1:0] b;
    while (tx_bytes.size() > 0) begin
      if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      b = tx_bytes.pop_front();
      in_valid <= 1'b1;
      in_byte  <= b;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      tracker.take_byte(b);
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    while (tracker.pending() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_mode(input bit m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.docid = m;
  endtask

  initial begin : result_side
    int unsigned hold;
    bit          calm;
    hold = 0;
    calm = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        tracker.check_result(value, status);
        if ($urandom_range(0, 31) == 0) calm = !calm;
        hold = calm ? 0 : $urandom_range(0, 5);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    tracker     = new();
    send_calm   = 1'b0;
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 1'b0;
    in_valid    <= 1'b0;
    in_byte     <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Plain mode: short and long extremes, a bad second byte, and a value left open.
    add_value(1, 64'h0);
    add_value(1, 64'h7F);
    add_value(2, 64'h0);
    add_value(9, '1);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(8'hC3);
    add_value(10, '1);
    tx_bytes.push_back(8'hC0);
    tx_bytes.push_back(8'h12);
    send_stream();
    settle();

    // The open value completes under docid mode with the type byte held from reset.
    write_mode(1'b1);
    tx_bytes.push_back(8'h34);
    tx_bytes.push_back(8'hFF);
    add_value(1, 64'h0);
    tx_bytes.push_back(8'hAB);
    add_value(1, 64'h1);
    tx_bytes.push_back(8'hFF);
    add_value(10, '1);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(8'hFF);
    send_stream();
    settle();

    for (int p = 0; p < RandomPhases; p++) begin
      write_mode(p % 2 == 1);
      build_random(p % 2 == 1);
      send_stream();
      settle();
    end

    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
